### hdl/sobb_pkg.sv
package sobb_pkg;

    // Field and register geometry.
    localparam int COORD_W     = 21;
    localparam int REG_W       = 3 * COORD_W;
    localparam int EPS_W       = 20;
    localparam int SCALE_SH    = COORD_W - 1;
    localparam int IN_W        = 6 * COORD_W;
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_IDX_W   = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_CENTER = 3'd0;
    localparam t_cfg_idx REG_AXIS0  = 3'd1;
    localparam t_cfg_idx REG_AXIS1  = 3'd2;
    localparam t_cfg_idx REG_AXIS2  = 3'd3;
    localparam t_cfg_idx REG_EXTENT = 3'd4;
    localparam t_cfg_idx REG_EPS    = 3'd5;

    // Reset values: unit axes along x, y and z (1.0 in Q1.19), epsilon of one lsb.
    localparam logic [REG_W-1:0] AXIS0_RST = REG_W'(1) << (COORD_W - 2);
    localparam logic [REG_W-1:0] AXIS1_RST = REG_W'(1) << (2 * COORD_W - 2);
    localparam logic [REG_W-1:0] AXIS2_RST = REG_W'(1) << (3 * COORD_W - 2);
    localparam logic [EPS_W-1:0] EPS_RST   = EPS_W'(1);

    // Datapath widths.
    localparam int REL_W = COORD_W + 3;          // s + f - 2c
    localparam int DIR_W = COORD_W + 1;          // f - s
    localparam int PM_W  = COORD_W + REL_W;
    localparam int PD_W  = COORD_W + DIR_W;
    localparam int M_W   = PM_W + 2;             // box-frame midpoint, doubled
    localparam int D_W   = PD_W + 2;             // box-frame direction, doubled
    localparam int EXS_W = COORD_W + SCALE_SH;   // scaled extent
    localparam int AD_W  = D_W + 1;              // |d| plus scaled epsilon
    localparam int ML_W  = (M_W + 1) / 2;
    localparam int MH_W  = M_W - ML_W;
    localparam int DL_W  = (D_W + 1) / 2;
    localparam int DH_W  = D_W - DL_W;
    localparam int PP_W  = ML_W + DL_W + 2;
    localparam int CP_W  = M_W + D_W;
    localparam int DF_W  = CP_W + 1;
    localparam int AL_W  = (AD_W + 1) / 2;
    localparam int AH_W  = AD_W - AL_W;
    localparam int RP_W  = COORD_W + AL_W;
    localparam int RQ_W  = COORD_W + AD_W;
    localparam int RS_W  = RQ_W + 1;

    localparam int NUM_STAGES = 8;

endpackage

### hdl/segment_obb_overlap_test_core.sv
// An accepted input word passes through stages 1 to 8 in order before its result word is on the output.
// Throughput: one segment per cycle while the output takes words; each of the eight register stages holds one word.
// A stage moves forward when it is empty or the stage after it moves, so empty
// stages fill up while the output word waits.
// Reset (i_rst_n low at a clock edge) empties the pipeline and loads the box
// registers with their defaults: unit axes, zero center and extents, epsilon 1.
module segment_obb_overlap_test_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration write port.
    input  logic                                 i_cfg_we,
    input  logic [sobb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [sobb_pkg::REG_W-1:0]           i_cfg_data,
    // Segment input.
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    // start_x, start_y, start_z, finish_x, finish_y, finish_z (21 bits each), zero pad
    input  logic [sobb_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // Result output.
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    // hit (bit 0), zero pad
    output logic [sobb_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata
);

    localparam int W  = sobb_pkg::COORD_W;
    localparam int NS = sobb_pkg::NUM_STAGES;

    // Configuration registers.
    logic [sobb_pkg::REG_W-1:0] r_center;
    logic [sobb_pkg::REG_W-1:0] r_axis [3];
    logic [sobb_pkg::REG_W-1:0] r_ext;
    logic [sobb_pkg::EPS_W-1:0] r_eps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center  <= '0;
            r_axis[0] <= sobb_pkg::AXIS0_RST;
            r_axis[1] <= sobb_pkg::AXIS1_RST;
            r_axis[2] <= sobb_pkg::AXIS2_RST;
            r_ext     <= '0;
            r_eps     <= sobb_pkg::EPS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sobb_pkg::REG_CENTER: r_center  <= i_cfg_data;
                sobb_pkg::REG_AXIS0:  r_axis[0] <= i_cfg_data;
                sobb_pkg::REG_AXIS1:  r_axis[1] <= i_cfg_data;
                sobb_pkg::REG_AXIS2:  r_axis[2] <= i_cfg_data;
                sobb_pkg::REG_EXTENT: r_ext     <= i_cfg_data;
                sobb_pkg::REG_EPS:    r_eps     <= i_cfg_data[sobb_pkg::EPS_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline control. Bit k of r_vld belongs to stage k+1; the last is the output.
    logic [NS-1:0] r_vld;
    logic [NS-1:0] s_adv;

    always_comb begin
        s_adv[NS-1] = ~r_vld[NS-1] | i_m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            s_adv[k] = ~r_vld[k] | s_adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (s_adv[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (s_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_s_axis_tready = s_adv[0];
    assign o_m_axis_tvalid = r_vld[NS-1];

    // Stage 1: doubled midpoint relative to the center, and direction.
    logic signed [sobb_pkg::REL_W-1:0] n_rel [3];
    logic signed [sobb_pkg::DIR_W-1:0] n_dir [3];
    logic signed [sobb_pkg::REL_W-1:0] r_rel [3];
    logic signed [sobb_pkg::DIR_W-1:0] r_dir [3];

    always_comb begin
        logic [W-1:0] s;
        logic [W-1:0] f;
        logic [W-1:0] c;
        for (int k = 0; k < 3; k++) begin
            s = i_s_axis_tdata[k*W +: W];
            f = i_s_axis_tdata[(k+3)*W +: W];
            c = r_center[k*W +: W];
            n_rel[k] = {{3{s[W-1]}}, s} + {{3{f[W-1]}}, f} - {{2{c[W-1]}}, c, 1'b0};
            n_dir[k] = {f[W-1], f} - {s[W-1], s};
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv[0]) begin
            for (int k = 0; k < 3; k++) begin
                r_rel[k] <= n_rel[k];
                r_dir[k] <= n_dir[k];
            end
        end
    end

    // Stage 2: component products with the box axes.
    logic signed [W-1:0]              n_u  [3][3];
    logic signed [sobb_pkg::PM_W-1:0] r_pm [3][3];
    logic signed [sobb_pkg::PD_W-1:0] r_pd [3][3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
                n_u[i][k] = $signed(r_axis[i][k*W +: W]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv[1]) begin
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < 3; k++) begin
                    r_pm[i][k] <= n_u[i][k] * r_rel[k];
                    r_pd[i][k] <= n_u[i][k] * r_dir[k];
                end
            end
        end
    end

    // Stage 3: dot products, midpoint and direction in the box frame.
    logic signed [sobb_pkg::M_W-1:0] r_m2 [3];
    logic signed [sobb_pkg::D_W-1:0] r_d2 [3];

    always_ff @(posedge i_clk) begin
        if (s_adv[2]) begin
            for (int i = 0; i < 3; i++) begin
                r_m2[i] <= sobb_pkg::M_W'(r_pm[i][0]) + sobb_pkg::M_W'(r_pm[i][1])
                         + sobb_pkg::M_W'(r_pm[i][2]);
                r_d2[i] <= sobb_pkg::D_W'(r_pd[i][0]) + sobb_pkg::D_W'(r_pd[i][1])
                         + sobb_pkg::D_W'(r_pd[i][2]);
            end
        end
    end

    // Stage 4: face-axis tests and the epsilon-padded direction magnitudes.
    logic [sobb_pkg::M_W-1:0]   n_am  [3];
    logic [sobb_pkg::D_W-1:0]   n_ad  [3];
    logic [sobb_pkg::M_W:0]     n_lim [3];
    logic [sobb_pkg::AD_W-1:0]  n_ade [3];
    logic [2:0]                 n_face_sep;
    logic signed [sobb_pkg::M_W-1:0] r_s4_m2 [3];
    logic signed [sobb_pkg::D_W-1:0] r_s4_d2 [3];
    logic [sobb_pkg::AD_W-1:0]       r_s4_ade [3];
    logic                            r_s4_face;

    always_comb begin
        logic [sobb_pkg::EXS_W-1:0] exs;
        for (int i = 0; i < 3; i++) begin
            exs = {r_ext[i*W +: W], {sobb_pkg::SCALE_SH{1'b0}}};
            n_am[i] = r_m2[i][sobb_pkg::M_W-1] ? sobb_pkg::M_W'(-r_m2[i])
                                                : sobb_pkg::M_W'(r_m2[i]);
            n_ad[i] = r_d2[i][sobb_pkg::D_W-1] ? sobb_pkg::D_W'(-r_d2[i])
                                                : sobb_pkg::D_W'(r_d2[i]);
            n_lim[i] = (sobb_pkg::M_W + 1)'(exs) + (sobb_pkg::M_W + 1)'(n_ad[i]);
            n_face_sep[i] = (sobb_pkg::M_W + 1)'(n_am[i]) > n_lim[i];
            n_ade[i] = sobb_pkg::AD_W'(n_ad[i])
                     + sobb_pkg::AD_W'({r_eps, {sobb_pkg::SCALE_SH{1'b0}}});
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv[3]) begin
            for (int i = 0; i < 3; i++) begin
                r_s4_m2[i]  <= r_m2[i];
                r_s4_d2[i]  <= r_d2[i];
                r_s4_ade[i] <= n_ade[i];
            end
            r_s4_face <= ~|n_face_sep;
        end
    end

    // Stage 5: partial products for the edge tests. Product j belongs to edge j/2;
    // the even one is m[a]*d[b] and ext[a]*ad[b], the odd one m[b]*d[a] and ext[b]*ad[a].
    logic signed [sobb_pkg::PP_W-1:0] r_pp_ll [6];
    logic signed [sobb_pkg::PP_W-1:0] r_pp_lh [6];
    logic signed [sobb_pkg::PP_W-1:0] r_pp_hl [6];
    logic signed [sobb_pkg::PP_W-1:0] r_pp_hh [6];
    logic [sobb_pkg::RP_W-1:0]        r_rp_lo [6];
    logic [sobb_pkg::RP_W-1:0]        r_rp_hi [6];
    logic                             r_s5_face;

    // Stage 6: full products.
    logic signed [sobb_pkg::CP_W-1:0] r_cp [6];
    logic [sobb_pkg::RQ_W-1:0]        r_rq [6];
    logic                             r_s6_face;

    for (genvar j = 0; j < 6; j++) begin : g_prod
        localparam int EI = j / 2;
        localparam int MI = (j % 2 == 0) ? (EI + 1) % 3 : (EI + 2) % 3;
        localparam int DI = (j % 2 == 0) ? (EI + 2) % 3 : (EI + 1) % 3;

        logic [sobb_pkg::ML_W-1:0]        m_lo;
        logic signed [sobb_pkg::MH_W-1:0] m_hi;
        logic [sobb_pkg::DL_W-1:0]        d_lo;
        logic signed [sobb_pkg::DH_W-1:0] d_hi;
        logic [W-1:0]                     ext_c;

        assign m_lo  = r_s4_m2[MI][sobb_pkg::ML_W-1:0];
        assign m_hi  = $signed(r_s4_m2[MI][sobb_pkg::M_W-1:sobb_pkg::ML_W]);
        assign d_lo  = r_s4_d2[DI][sobb_pkg::DL_W-1:0];
        assign d_hi  = $signed(r_s4_d2[DI][sobb_pkg::D_W-1:sobb_pkg::DL_W]);
        assign ext_c = r_ext[MI*W +: W];

        always_ff @(posedge i_clk) begin
            if (s_adv[4]) begin
                r_pp_ll[j] <= $signed({1'b0, m_lo}) * $signed({1'b0, d_lo});
                r_pp_lh[j] <= $signed({1'b0, m_lo}) * d_hi;
                r_pp_hl[j] <= m_hi * $signed({1'b0, d_lo});
                r_pp_hh[j] <= m_hi * d_hi;
                r_rp_lo[j] <= ext_c * r_s4_ade[DI][sobb_pkg::AL_W-1:0];
                r_rp_hi[j] <= ext_c * r_s4_ade[DI][sobb_pkg::AD_W-1:sobb_pkg::AL_W];
            end
        end

        always_ff @(posedge i_clk) begin
            if (s_adv[5]) begin
                r_cp[j] <= (sobb_pkg::CP_W'(r_pp_hh[j]) <<< (sobb_pkg::ML_W + sobb_pkg::DL_W))
                         + (sobb_pkg::CP_W'(r_pp_hl[j]) <<< sobb_pkg::ML_W)
                         + (sobb_pkg::CP_W'(r_pp_lh[j]) <<< sobb_pkg::DL_W)
                         + sobb_pkg::CP_W'(r_pp_ll[j]);
                r_rq[j] <= (sobb_pkg::RQ_W'(r_rp_hi[j]) << sobb_pkg::AL_W)
                         + sobb_pkg::RQ_W'(r_rp_lo[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv[4]) begin
            r_s5_face <= r_s4_face;
        end
        if (s_adv[5]) begin
            r_s6_face <= r_s5_face;
        end
    end

    // Stage 7: cross-product difference and right-hand side of each edge test.
    logic signed [sobb_pkg::DF_W-1:0] r_diff [3];
    logic [sobb_pkg::RS_W-1:0]        r_rhs  [3];
    logic                             r_s7_face;

    always_ff @(posedge i_clk) begin
        if (s_adv[6]) begin
            for (int i = 0; i < 3; i++) begin
                r_diff[i] <= sobb_pkg::DF_W'(r_cp[2*i]) - sobb_pkg::DF_W'(r_cp[2*i+1]);
                r_rhs[i]  <= sobb_pkg::RS_W'(r_rq[2*i]) + sobb_pkg::RS_W'(r_rq[2*i+1]);
            end
            r_s7_face <= r_s6_face;
        end
    end

    // Stage 8: |diff| > rhs, tested as diff > rhs or diff < -rhs.
    logic signed [sobb_pkg::DF_W-1:0] n_rhs_s [3];
    logic [2:0]                       n_edge_sep;
    logic                             r_hit;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_rhs_s[i] = $signed(sobb_pkg::DF_W'({r_rhs[i], {sobb_pkg::SCALE_SH{1'b0}}}));
            n_edge_sep[i] = (r_diff[i] > n_rhs_s[i]) || (r_diff[i] < -n_rhs_s[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_adv[7]) begin
            r_hit <= r_s7_face & ~|n_edge_sep;
        end
    end

    assign o_m_axis_tdata = {{(sobb_pkg::OUT_TDATA_W-1){1'b0}}, r_hit};

    // An empty stage anywhere in the pipeline means a word can be taken.
    a_ready_with_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(&r_vld) |-> o_s_axis_tready)
        else $error("input stalled while the pipeline has an empty stage");

    // A word taken at the input lands in the first stage.
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> r_vld[0])
        else $error("accepted word did not enter the first stage");

    // A face-axis separation always forces a miss.
    a_face_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NS-2] && s_adv[NS-1] && !r_s7_face |=> o_m_axis_tvalid && !r_hit)
        else $error("face separation did not produce a miss");

endmodule
